/* rtl/core/multi_channel_step_pulse_generator_top_defines.svh */
// Assertion macros shared by the checker of the step pulse generator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef MULTI_CHANNEL_STEP_PULSE_GENERATOR_TOP_DEFINES_SVH
`define MULTI_CHANNEL_STEP_PULSE_GENERATOR_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MCSPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MCSPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mcspg_pkg.sv */
// Package of the multi-channel step pulse generator: sizes, field offsets,
// register codes and the command type passed from the front end to the back end.
// No dependencies.
package mcspg_pkg;

  localparam int NUM_CHANNELS = 11;
  localparam int COUNT_WIDTH  = 32;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int GUARDS      = 4;
  localparam int MOTOR_IDX_W = 4;
  localparam int LIMIT_W     = 4;
  localparam int OUT_MASK_W  = 11;

  // Input item layout in in_tdata.
  localparam int IDX_LSB   = 0;
  localparam int DIR_BIT   = IDX_LSB + MOTOR_IDX_W;
  localparam int CNT_LSB   = DIR_BIT + 1;
  localparam int LIM_LSB   = CNT_LSB + 32;
  localparam int IN_DATA_W = 48;

  // Result item layout in out_tdata.
  localparam int PULSE_LSB  = 0;
  localparam int DIRM_LSB   = PULSE_LSB + OUT_MASK_W;
  localparam int ROT_BIT    = DIRM_LSB + OUT_MASK_W;
  localparam int REJ_BIT    = ROT_BIT + 1;
  localparam int OUT_DATA_W = 24;

  // Command codes carried in in_tuser.
  localparam logic CMD_RUN  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_B      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_C      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_D      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_MASK = 3'd4;

  localparam logic [MOTOR_IDX_W-1:0] GUARD_RESET [GUARDS] = '{4'd1, 4'd2, 4'd4, 4'd9};
  localparam logic [GUARDS-1:0] BLOCKED_RESET = 4'd13;

  // Command queue depth.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_TICK,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [CH_IDX_W-1:0]    chan;
    logic                   dir;
    logic [COUNT_WIDTH-1:0] count;
  } cmd_t;

endpackage

/* rtl/core/mcspg_front.sv */
// Front end: holds the guard configuration and classifies each input item
// as a channel load, a tick or a rejected command. Uses mcspg_pkg.
module mcspg_front import mcspg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  output cmd_t                  cmd
);

  logic [MOTOR_IDX_W-1:0] guard_r [GUARDS];
  logic [GUARDS-1:0]      blocked_r;

  logic [MOTOR_IDX_W-1:0] idx;
  logic                   dir;
  logic [LIMIT_W-1:0]     lim;
  logic                   refuse;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < GUARDS; i++) begin
        guard_r[i] <= GUARD_RESET[i];
      end
      blocked_r <= BLOCKED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GUARD_A:      guard_r[0] <= cfg_wdata;
        REG_GUARD_B:      guard_r[1] <= cfg_wdata;
        REG_GUARD_C:      guard_r[2] <= cfg_wdata;
        REG_GUARD_D:      guard_r[3] <= cfg_wdata;
        REG_BLOCKED_MASK: blocked_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign idx = in_tdata[IDX_LSB +: MOTOR_IDX_W];
  assign dir = in_tdata[DIR_BIT];
  assign lim = in_tdata[LIM_LSB +: LIMIT_W];

  always_comb begin
    // An index past the last channel is always refused.
    refuse = ({1'b0, idx} >= (MOTOR_IDX_W + 1)'(NUM_CHANNELS));
    for (int i = 0; i < GUARDS; i++) begin
      if (lim[i] && (idx == guard_r[i]) && (dir == blocked_r[i])) begin
        refuse = 1'b1;
      end
    end
  end

  always_comb begin
    if (in_tuser == CMD_TICK) begin
      cmd.op = OP_TICK;
    end else if (refuse) begin
      cmd.op = OP_REJECT;
    end else begin
      cmd.op = OP_LOAD;
    end
    cmd.chan  = idx[CH_IDX_W-1:0];
    cmd.dir   = dir;
    cmd.count = in_tdata[CNT_LSB +: COUNT_WIDTH];
  end

endmodule

/* rtl/core/mcspg_queue.sv */
// Short command queue between the front end and the back end, so that
// each side can stall on its own. Uses mcspg_pkg.
module mcspg_queue import mcspg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = rst_n && (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];

  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/core/mcspg_back.sv */
// Back end: the per-channel step counters and direction bits, the busy flag,
// and the registered result item. Uses mcspg_pkg.
module mcspg_back import mcspg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  cmd_t                  q_cmd,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [COUNT_WIDTH-1:0] rem_r [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] rem_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] dir_r, dir_nxt;
  logic                    busy_r, busy_nxt;
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  logic                    pop;
  logic [NUM_CHANNELS-1:0] pulse;
  logic                    rej;
  logic [OUT_MASK_W-1:0]   pulse_lines;
  logic [OUT_MASK_W-1:0]   dir_lines;

  // The result register takes a new item whenever it is empty or draining.
  assign q_ready = !out_valid_r || out_tready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    rem_nxt  = rem_r;
    dir_nxt  = dir_r;
    busy_nxt = busy_r;
    pulse    = '0;
    rej      = 1'b0;
    if (pop) begin
      case (q_cmd.op)
        OP_TICK: begin
          for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (rem_r[ch] != '0) begin
              pulse[ch]   = 1'b1;
              rem_nxt[ch] = rem_r[ch] - COUNT_WIDTH'(1);
            end
          end
          busy_nxt = |pulse;
        end
        OP_LOAD: begin
          rem_nxt[q_cmd.chan] = q_cmd.count;
          dir_nxt[q_cmd.chan] = q_cmd.dir;
        end
        OP_REJECT: begin
          rej = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    pulse_lines = '0;
    dir_lines   = '0;
    for (int i = 0; i < OUT_MASK_W; i++) begin
      if (i < NUM_CHANNELS) begin
        pulse_lines[i] = pulse[i];
        dir_lines[i]   = dir_nxt[i];
      end
    end
    out_data_nxt = {rej, busy_nxt, dir_lines, pulse_lines};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        rem_r[ch] <= '0;
      end
      dir_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      dir_r  <= dir_nxt;
      busy_r <= busy_nxt;
      if (q_ready) begin
        out_valid_r <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/core/multi_channel_step_pulse_generator_top.sv */
// Step and direction generator for eleven stepper channels, taking one item per
// clock cycle while in_tready is high. An item is either a run command (in_tuser
// low) that loads one channel's step count and direction, or a tick (in_tuser
// high) that pulses every channel whose count is nonzero and counts it down. Each
// item yields exactly one result item: the classified command is written into the
// queue when the item is accepted, and the back end registers the result when it
// pops the command while the output is not stalled. The front end checks the run
// command against the four limit-switch guards and the channel range and
// classifies the item; a two-entry command queue then feeds the back end, which
// holds all counters and updates them in parallel. Sustained rate is one item
// per cycle while out_tready stays high, set by the queue's full flag and the
// single result register; when out_tready stays low, the queue fills and
// in_tready drops after two more items. Configuration writes take effect on the
// next clock edge and must only be made while the block is idle.
// Depends on mcspg_pkg, mcspg_front, mcspg_queue and mcspg_back.
module multi_channel_step_pulse_generator_top import mcspg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input items.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tdata, low bit first: motor_index[3:0], direction[4],
  // step_count[36:5], switch_flags[40:37], zero fill [47:41].
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: command (0 = run command, 1 = tick).
  input  logic                  in_tuser,
  // Result items.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata, low bit first: pulse_mask[10:0], direction_mask[21:11],
  // rotating[22], rejected[23].
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_ready;

  // Classification is combinational; the classified command enters the queue
  // at the edge where the item is accepted.
  mcspg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (front_cmd)
  );

  mcspg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  // The back end carries out one command per cycle while its result
  // register can take the result.
  mcspg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/core/mcspg_checker.sv */
// Port-level checker for the step pulse generator and its bind to the top level.
// Uses mcspg_pkg and the assertion macros of the top level's defines header.
`include "multi_channel_step_pulse_generator_top_defines.svh"

module mcspg_checker import mcspg_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  `MCSPG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result item changed")
  `MCSPG_ASSERT_NOW(a_pulse_busy, out_tvalid && (out_tdata[PULSE_LSB +: OUT_MASK_W] != '0), out_tdata[ROT_BIT], "pulses shown without the busy flag")
  `MCSPG_ASSERT_NOW(a_rej_no_pulse, out_tvalid && out_tdata[REJ_BIT], out_tdata[PULSE_LSB +: OUT_MASK_W] == '0, "rejected command shows pulses")

endmodule

bind multi_channel_step_pulse_generator_top mcspg_checker u_mcspg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
